[rtl/triangle_midpoint_subdivider_assert.svh]
// Assertion macros used by the checker module.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define TMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TMS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tms_pkg.sv]
package tms_pkg;

   localparam int IDX_W          = 12;
   localparam int COORD_W        = 32;
   localparam int MAG_W          = 32;
   localparam int PROD_W         = 2 * MAG_W;
   localparam int DIST_W         = PROD_W + 2;
   localparam int NODE_COUNT_DEF = 4096;
   localparam int QUEUE_DEPTH    = 2;

   typedef logic [IDX_W-1:0] idx_type;

   // how the back end handles a queued item
   typedef enum logic [2:0] {
      OP_WRITE,
      OP_PASS,
      OP_SPLIT4,
      OP_OPEN01,
      OP_OPEN12,
      OP_OPEN20
   } op_type;

   typedef struct packed {
      op_type                op;
      idx_type               node_index;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [COORD_W-1:0]    z;
      idx_type [5:0]         nodes;   // corners 0..2, midpoints 3..5
   } entry_type;

   typedef struct packed {
      idx_type a;
      idx_type b;
      idx_type c;
      logic    last;
   } piece_type;

   typedef struct packed {
      logic      valid;
      entry_type head;
   } queue_out_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ADDR_A,
      B_ADDR_B,
      B_DIFF,
      B_SQUARE,
      B_EMIT
   } back_state_type;

endpackage

[rtl/tms_ram.sv]
module tms_ram #(
   parameter int WIDTH = 3 * tms_pkg::COORD_W,
   parameter int DEPTH = tms_pkg::NODE_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tms_front.sv]
module tms_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  tms_pkg::idx_type                 req_node_index,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_z,
   input  tms_pkg::idx_type                 req_corner_zero,
   input  tms_pkg::idx_type                 req_corner_one,
   input  tms_pkg::idx_type                 req_corner_two,
   input  tms_pkg::idx_type                 req_mid_first_edge,
   input  tms_pkg::idx_type                 req_mid_second_edge,
   input  tms_pkg::idx_type                 req_mid_third_edge,
   input  logic                             q_full,
   output logic                             q_push,
   output tms_pkg::entry_type               q_entry
);

   logic m0_zero;
   logic m1_zero;
   logic m2_zero;

   assign m0_zero = (req_mid_first_edge == '0);
   assign m1_zero = (req_mid_second_edge == '0);
   assign m2_zero = (req_mid_third_edge == '0);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.node_index = req_node_index;
      q_entry.x          = req_coord_x;
      q_entry.y          = req_coord_y;
      q_entry.z          = req_coord_z;
      q_entry.nodes[0]   = req_corner_zero;
      q_entry.nodes[1]   = req_corner_one;
      q_entry.nodes[2]   = req_corner_two;
      q_entry.nodes[3]   = req_mid_first_edge;
      q_entry.nodes[4]   = req_mid_second_edge;
      q_entry.nodes[5]   = req_mid_third_edge;
      // branch order: point write, none split, all split, then first unsplit edge wins
      priority if (!req_action) begin
         q_entry.op = tms_pkg::OP_WRITE;
      end else if (m0_zero && m1_zero && m2_zero) begin
         q_entry.op = tms_pkg::OP_PASS;
      end else if (!m0_zero && !m1_zero && !m2_zero) begin
         q_entry.op = tms_pkg::OP_SPLIT4;
      end else if (m0_zero) begin
         q_entry.op = tms_pkg::OP_OPEN01;
      end else if (m1_zero) begin
         q_entry.op = tms_pkg::OP_OPEN12;
      end else begin
         q_entry.op = tms_pkg::OP_OPEN20;
      end
   end

endmodule

[rtl/tms_queue.sv]
module tms_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tms_pkg::entry_type     push_entry,
   input  logic                   pop,
   output logic                   full,
   output tms_pkg::queue_out_type q_out
);

   localparam int PTR_W = (tms_pkg::QUEUE_DEPTH > 1) ? $clog2(tms_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tms_pkg::QUEUE_DEPTH + 1);

   tms_pkg::entry_type slot_ff [tms_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full         = (count_ff == CNT_W'(tms_pkg::QUEUE_DEPTH));
   assign do_pop       = pop && (count_ff != '0);
   assign q_out.valid  = (count_ff != '0);
   assign q_out.head   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(tms_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(tms_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/tms_back.sv]
module tms_back #(
   parameter int NODE_COUNT = tms_pkg::NODE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tms_pkg::queue_out_type q_out,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tms_pkg::piece_type     rsp_piece
);

   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam int PT_W   = 3 * tms_pkg::COORD_W;

   typedef logic [2:0][tms_pkg::COORD_W-1:0] point_type;
   typedef logic [2:0][tms_pkg::MAG_W-1:0]   mag_type;

   function automatic logic in_store(tms_pkg::idx_type i);
      return 32'(i) < NODE_COUNT;
   endfunction

   // sel = {pair, second point of pair}
   function automatic tms_pkg::idx_type cmp_node(tms_pkg::op_type op, logic [1:0] sel,
                                                 tms_pkg::idx_type [5:0] n);
      tms_pkg::idx_type r;
      r = '0;
      unique case (op)
         tms_pkg::OP_OPEN01: begin
            unique case (sel)
               2'd0:    r = n[0];
               2'd1:    r = n[4];
               2'd2:    r = n[1];
               default: r = n[5];
            endcase
         end
         tms_pkg::OP_OPEN12: begin
            unique case (sel)
               2'd0:    r = n[1];
               2'd1:    r = n[5];
               2'd2:    r = n[2];
               default: r = n[3];
            endcase
         end
         default: begin
            unique case (sel)
               2'd0:    r = n[2];
               2'd1:    r = n[3];
               2'd2:    r = n[0];
               default: r = n[4];
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic tms_pkg::piece_type mk(tms_pkg::idx_type a, tms_pkg::idx_type b,
                                             tms_pkg::idx_type c, logic last);
      tms_pkg::piece_type p;
      p.a    = a;
      p.b    = b;
      p.c    = c;
      p.last = last;
      return p;
   endfunction

   function automatic tms_pkg::piece_type pick_piece(tms_pkg::op_type op, logic sh,
                                                     logic [1:0] k,
                                                     tms_pkg::idx_type [5:0] n);
      tms_pkg::piece_type p;
      p = '0;
      unique case (op)
         tms_pkg::OP_PASS: p = mk(n[0], n[1], n[2], 1'b1);
         tms_pkg::OP_SPLIT4: begin
            unique case (k)
               2'd0:    p = mk(n[0], n[3], n[5], 1'b0);
               2'd1:    p = mk(n[3], n[1], n[4], 1'b0);
               2'd2:    p = mk(n[4], n[2], n[5], 1'b0);
               default: p = mk(n[3], n[4], n[5], 1'b1);
            endcase
         end
         tms_pkg::OP_OPEN01: begin
            unique case (k)
               2'd0:    p = mk(n[4], n[2], n[5], 1'b0);
               2'd1:    p = sh ? mk(n[4], n[5], n[0], 1'b0) : mk(n[4], n[5], n[1], 1'b0);
               default: p = sh ? mk(n[0], n[1], n[4], 1'b1) : mk(n[0], n[1], n[5], 1'b1);
            endcase
         end
         tms_pkg::OP_OPEN12: begin
            unique case (k)
               2'd0:    p = mk(n[0], n[3], n[5], 1'b0);
               2'd1:    p = sh ? mk(n[3], n[1], n[5], 1'b0) : mk(n[3], n[2], n[5], 1'b0);
               default: p = sh ? mk(n[1], n[2], n[5], 1'b1) : mk(n[1], n[2], n[3], 1'b1);
            endcase
         end
         tms_pkg::OP_OPEN20: begin
            unique case (k)
               2'd0:    p = mk(n[1], n[4], n[3], 1'b0);
               2'd1:    p = sh ? mk(n[3], n[2], n[0], 1'b0) : mk(n[4], n[2], n[0], 1'b0);
               default: p = sh ? mk(n[2], n[3], n[4], 1'b1) : mk(n[0], n[3], n[4], 1'b1);
            endcase
         end
         default: p = '0;
      endcase
      return p;
   endfunction

   tms_pkg::back_state_type state_ff, state_in;
   tms_pkg::op_type         op_ff, op_in;
   tms_pkg::idx_type [5:0]  nodes_ff, nodes_in;
   logic                    pair_ff, pair_in;
   logic [1:0]              sq_cnt_ff, sq_cnt_in;
   logic [1:0]              piece_cnt_ff, piece_cnt_in;
   logic                    rd_ok_ff, rd_ok_in;
   point_type               pt_a_ff, pt_a_in;
   mag_type                 mag_ff, mag_in;
   logic [tms_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [tms_pkg::DIST_W-1:0] acc_ff, acc_in;
   logic [tms_pkg::DIST_W-1:0] first_ff, first_in;
   logic [tms_pkg::DIST_W-1:0] dist_sum;
   logic                    shorter_ff, shorter_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tms_pkg::piece_type      rsp_ff, rsp_in;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [PT_W-1:0]         ram_wr_data;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [PT_W-1:0]         ram_rd_data;
   tms_pkg::idx_type        rd_idx;
   point_type               pt_b;
   logic [tms_pkg::MAG_W-1:0] mag_sel;
   logic                    rsp_load;
   tms_pkg::piece_type      piece;
   logic [tms_pkg::COORD_W:0] diff [3];

   tms_ram #(
      .WIDTH (PT_W),
      .DEPTH (NODE_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_idx      = cmp_node(op_ff, {pair_ff, state_ff == tms_pkg::B_ADDR_B}, nodes_ff);
   assign ram_rd_addr = ADDR_W'(rd_idx);
   assign rd_ok_in    = in_store(rd_idx);
   assign ram_wr_addr = ADDR_W'(q_out.head.node_index);
   assign ram_wr_data = {q_out.head.z, q_out.head.y, q_out.head.x};
   assign pt_b        = rd_ok_ff ? point_type'(ram_rd_data) : '0;
   assign piece       = pick_piece(op_ff, shorter_ff, piece_cnt_ff, nodes_ff);
   assign rsp_load    = (state_ff == tms_pkg::B_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign dist_sum    = acc_ff + {2'b00, prod_ff};

   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    mag_sel = mag_ff[0];
         2'd1:    mag_sel = mag_ff[1];
         2'd2:    mag_sel = mag_ff[2];
         default: mag_sel = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tms_pkg::B_IDLE: begin
            if (q_out.valid) begin
               unique case (q_out.head.op)
                  tms_pkg::OP_WRITE:                    state_in = tms_pkg::B_IDLE;
                  tms_pkg::OP_PASS, tms_pkg::OP_SPLIT4: state_in = tms_pkg::B_EMIT;
                  default:                              state_in = tms_pkg::B_ADDR_A;
               endcase
            end
         end
         tms_pkg::B_ADDR_A: state_in = tms_pkg::B_ADDR_B;
         tms_pkg::B_ADDR_B: state_in = tms_pkg::B_DIFF;
         tms_pkg::B_DIFF:   state_in = tms_pkg::B_SQUARE;
         tms_pkg::B_SQUARE: begin
            if (sq_cnt_ff == 2'd3) begin
               state_in = pair_ff ? tms_pkg::B_EMIT : tms_pkg::B_ADDR_A;
            end
         end
         tms_pkg::B_EMIT: begin
            if (rsp_load && piece.last) begin
               state_in = tms_pkg::B_IDLE;
            end
         end
         default: state_in = tms_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      op_in        = op_ff;
      nodes_in     = nodes_ff;
      pair_in      = pair_ff;
      sq_cnt_in    = sq_cnt_ff;
      piece_cnt_in = piece_cnt_ff;
      pt_a_in      = pt_a_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      first_in     = first_ff;
      shorter_in   = shorter_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      for (int k = 0; k < 3; k++) begin
         diff[k] = {pt_a_ff[k][tms_pkg::COORD_W-1], pt_a_ff[k]}
                 - {pt_b[k][tms_pkg::COORD_W-1], pt_b[k]};
      end
      unique case (state_ff)
         tms_pkg::B_IDLE: begin
            q_pop        = q_out.valid;
            ram_wr_en    = q_out.valid && (q_out.head.op == tms_pkg::OP_WRITE)
                           && in_store(q_out.head.node_index);
            op_in        = q_out.head.op;
            nodes_in     = q_out.head.nodes;
            pair_in      = 1'b0;
            piece_cnt_in = '0;
         end
         tms_pkg::B_ADDR_A: begin
         end
         tms_pkg::B_ADDR_B: begin
            pt_a_in = rd_ok_ff ? point_type'(ram_rd_data) : '0;
         end
         tms_pkg::B_DIFF: begin
            // magnitude of a 33-bit difference always fits 32 bits
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = diff[k][tms_pkg::COORD_W] ? (~diff[k][tms_pkg::MAG_W-1:0] + 1'b1)
                                                     : diff[k][tms_pkg::MAG_W-1:0];
            end
            sq_cnt_in = '0;
            acc_in    = '0;
         end
         tms_pkg::B_SQUARE: begin
            prod_in   = mag_sel * mag_sel;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff != 2'd0) begin
               acc_in = dist_sum;
            end
            if (sq_cnt_ff == 2'd3) begin
               if (!pair_ff) begin
                  first_in = dist_sum;
                  pair_in  = 1'b1;
               end else begin
                  shorter_in = (first_ff < dist_sum);
               end
            end
         end
         tms_pkg::B_EMIT: begin
            if (rsp_load) begin
               rsp_in       = piece;
               piece_cnt_in = piece_cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tms_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      nodes_ff     <= nodes_in;
      pair_ff      <= pair_in;
      sq_cnt_ff    <= sq_cnt_in;
      piece_cnt_ff <= piece_cnt_in;
      rd_ok_ff     <= rd_ok_in;
      pt_a_ff      <= pt_a_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      first_ff     <= first_in;
      shorter_ff   <= shorter_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_piece = rsp_ff;

endmodule

[rtl/triangle_midpoint_subdivider.sv]
// Channel   Ports                                   Moves
// req       req_valid / req_stall, req_* fields     point write or triangle, one per transfer
// rsp       rsp_valid / rsp_stall, rsp_* fields     one sub-triangle per transfer
//
// Point write: handled in the back end's idle state once it reaches the queue head.
// Unsplit or fully split triangle: dequeued, then one or four sub-triangles
// are sent. Partly split: paced by the single store read port and the one
// shared 32x32 squarer (two squared lengths, three terms each).
// Reset is synchronous; it empties the queue and the output register. The point
// store is not cleared. A two-entry queue lets req keep transferring while the
// back end waits on rsp_stall.
module triangle_midpoint_subdivider #(
   parameter int NODE_COUNT = tms_pkg::NODE_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [tms_pkg::IDX_W-1:0]          req_node_index,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [tms_pkg::COORD_W-1:0] req_coord_z,
   input  logic [tms_pkg::IDX_W-1:0]          req_corner_zero,
   input  logic [tms_pkg::IDX_W-1:0]          req_corner_one,
   input  logic [tms_pkg::IDX_W-1:0]          req_corner_two,
   input  logic [tms_pkg::IDX_W-1:0]          req_mid_first_edge,
   input  logic [tms_pkg::IDX_W-1:0]          req_mid_second_edge,
   input  logic [tms_pkg::IDX_W-1:0]          req_mid_third_edge,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tms_pkg::IDX_W-1:0]          rsp_vert_a,
   output logic [tms_pkg::IDX_W-1:0]          rsp_vert_b,
   output logic [tms_pkg::IDX_W-1:0]          rsp_vert_c,
   output logic                               rsp_last_piece
);

   // front -> queue
   logic                   q_full;
   logic                   q_push;
   tms_pkg::entry_type     q_entry;
   // queue -> back
   tms_pkg::queue_out_type q_out;
   logic                   q_pop;
   tms_pkg::piece_type     rsp_piece;

   // classify each transfer into a back-end op
   tms_front u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_node_index      (req_node_index),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .req_coord_z         (req_coord_z),
      .req_corner_zero     (req_corner_zero),
      .req_corner_one      (req_corner_one),
      .req_corner_two      (req_corner_two),
      .req_mid_first_edge  (req_mid_first_edge),
      .req_mid_second_edge (req_mid_second_edge),
      .req_mid_third_edge  (req_mid_third_edge),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_entry             (q_entry)
   );

   // point writes go through the queue too, so they stay ordered with reads
   tms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .q_out      (q_out)
   );

   // store, diagonal compare and triangle emit
   tms_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_piece (rsp_piece)
   );

   assign rsp_vert_a     = rsp_piece.a;
   assign rsp_vert_b     = rsp_piece.b;
   assign rsp_vert_c     = rsp_piece.c;
   assign rsp_last_piece = rsp_piece.last;

endmodule

[rtl/tms_checker.sv]
`include "triangle_midpoint_subdivider_assert.svh"

module tms_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [tms_pkg::IDX_W-1:0] rsp_vert_a,
   input logic [tms_pkg::IDX_W-1:0] rsp_vert_b,
   input logic [tms_pkg::IDX_W-1:0] rsp_vert_c,
   input logic                      rsp_last_piece
);

   `TMS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid,
      "rsp valid dropped while stalled")
   `TMS_ASSERT(a_rsp_stable, clock, reset,
      rsp_valid && rsp_stall |=> $stable(rsp_vert_a) && $stable(rsp_vert_b)
         && $stable(rsp_vert_c) && $stable(rsp_last_piece),
      "rsp payload changed while stalled")
   `TMS_ASSERT_ALWAYS(a_reset_clear, clock,
      reset |=> !rsp_valid && !req_stall,
      "queue or output not empty after reset")
   `TMS_ASSERT(a_pieces_back_to_back, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_piece |=> rsp_valid,
      "gap inside one triangle's pieces")

endmodule

bind triangle_midpoint_subdivider tms_checker u_tms_checker (.*);
